>>> design/pcs_pkg.sv
// Shared constants and types for the partition cut statistics unit.
// No dependencies; the top level takes everything here by scoped names.
package pcs_pkg;

    localparam int MAX_INTERVALS = 16;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int ICNT_W        = $clog2(MAX_INTERVALS + 1);
    localparam int ID_BITS       = 32;
    localparam int CNT_W         = 32;
    localparam int CFG_W         = 5;
    localparam int PART_W        = 4;
    localparam int KIND_W        = 2;
    localparam int IN_DATA_W     = 112;
    localparam int OUT_DATA_W    = 96;
    localparam int PAIR_DEPTH    = MAX_INTERVALS * MAX_INTERVALS;
    localparam int PAIR_AW       = 2 * IDX_W;

    // Bit positions of the input word fields.
    localparam int VID_LSB   = 0;
    localparam int HAS_BIT   = 32;
    localparam int NID_LSB   = 33;
    localparam int ROW_LSB   = 65;
    localparam int COL_LSB   = 69;
    localparam int START_LSB = 73;

    typedef enum logic [KIND_W-1:0] {
        K_LOAD   = 2'd0,
        K_VERTEX = 2'd1,
        K_EDGE   = 2'd2,
        K_READ   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RMW  = 2'b10
    } t_state;

endpackage

>>> design/partition_cut_statistics_unit.sv
// Top level of the partition cut statistics unit: interval lookup, counter
// memories with read-modify-write, and the result register. Uses pcs_pkg.
//
//  channel | dir | handshake              | payload
//  s       | in  | i_s_tvalid/o_s_tready  | i_s_tdata, i_s_tuser (kind), i_s_tlast (last_edge)
//  m       | out | o_m_tvalid/i_m_tready  | o_m_tdata (pair, boundary, active)
//  cfg     | in  | i_cfg_we               | i_cfg_wdata (interval_count)
//
// A load word is taken in its accept cycle. Vertex, edge and read words go
// on to S_RMW: the accept cycle looks up the interval and reads the counter
// memories, then S_RMW increments and writes back (a read loads the result); a
// read word stays in S_RMW while the result register still holds an untaken result.
// Reset is synchronous and clears all counters through per-entry valid bits.
module partition_cut_statistics_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pcs_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // vid, has_edges, neighbor_id, part_row, part_col, base_id, zero fill
    input  logic [pcs_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // kind
    input  logic [pcs_pkg::KIND_W-1:0]      i_s_tuser,
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // pair_edges, boundary_vertices, active_vertices
    output logic [pcs_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    localparam int IDX_W = pcs_pkg::IDX_W;
    localparam int CNT_W = pcs_pkg::CNT_W;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
    endfunction

    // Input word fields.
    logic [pcs_pkg::ID_BITS-1:0] w_vid, w_nid, w_start;
    logic                        w_has;
    logic [IDX_W-1:0]            w_row, w_col;
    pcs_pkg::t_kind              w_kind;

    assign w_vid   = i_s_tdata[pcs_pkg::VID_LSB +: pcs_pkg::ID_BITS];
    assign w_has   = i_s_tdata[pcs_pkg::HAS_BIT];
    assign w_nid   = i_s_tdata[pcs_pkg::NID_LSB +: pcs_pkg::ID_BITS];
    assign w_row   = i_s_tdata[pcs_pkg::ROW_LSB +: IDX_W];
    assign w_col   = i_s_tdata[pcs_pkg::COL_LSB +: IDX_W];
    assign w_start = i_s_tdata[pcs_pkg::START_LSB +: pcs_pkg::ID_BITS];
    assign w_kind  = pcs_pkg::t_kind'(i_s_tuser);

    // Control state.
    pcs_pkg::t_state              r_state;
    logic [pcs_pkg::CFG_W-1:0]    r_icount;
    logic [IDX_W-1:0]             r_cur;
    logic                         r_cross;
    logic                         r_m_valid;

    // Item held for the write-back cycle.
    pcs_pkg::t_kind               r_kind;
    logic                         r_has;
    logic                         r_last;
    logic [pcs_pkg::PAIR_AW-1:0]  r_pair_addr;
    logic [IDX_W-1:0]             r_bnd_addr;
    logic [IDX_W-1:0]             r_act_addr;

    // Interval start table, undefined until loaded.
    logic [pcs_pkg::ID_BITS-1:0]  r_starts [pcs_pkg::MAX_INTERVALS];

    // Counter memories with registered read data and per-entry valid bits.
    logic [CNT_W-1:0]             r_pair_mem [pcs_pkg::PAIR_DEPTH];
    logic [CNT_W-1:0]             r_bnd_mem  [pcs_pkg::MAX_INTERVALS];
    logic [CNT_W-1:0]             r_act_mem  [pcs_pkg::MAX_INTERVALS];
    logic [pcs_pkg::PAIR_DEPTH-1:0]    r_pair_vld;
    logic [pcs_pkg::MAX_INTERVALS-1:0] r_bnd_vld;
    logic [pcs_pkg::MAX_INTERVALS-1:0] r_act_vld;
    logic [CNT_W-1:0]             r_pair_rd, r_bnd_rd, r_act_rd;
    logic                         r_pair_rd_vld, r_bnd_rd_vld, r_act_rd_vld;
    logic [CNT_W-1:0]             r_m_pair, r_m_bnd, r_m_act;

    logic                         s_acc;
    logic                         m_free;
    logic [pcs_pkg::ID_BITS-1:0]  lk_id;
    logic [pcs_pkg::ICNT_W-1:0]   lk_n;
    logic                         lk_found;
    logic [IDX_W-1:0]             lk_idx;
    logic [pcs_pkg::PAIR_AW-1:0]  n_pair_addr;
    logic [IDX_W-1:0]             n_bnd_addr;
    logic [IDX_W-1:0]             n_act_addr;
    logic [CNT_W-1:0]             pair_cur, bnd_cur, act_cur;
    logic                         e_cross;
    logic                         pair_we, bnd_we, act_we;
    logic                         rd_done;
    pcs_pkg::t_state              n_state;

    assign o_s_tready = (r_state == pcs_pkg::S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_free     = !r_m_valid || i_m_tready;

    // Interval lookup: the first entry whose start exceeds the id ends the
    // search; the interval is the one before it, clamped to 0; if none does, the last in use.
    always_comb begin
        lk_id = (w_kind == pcs_pkg::K_VERTEX) ? w_vid : w_nid;
        lk_n  = (r_icount > pcs_pkg::CFG_W'(pcs_pkg::MAX_INTERVALS))
              ? pcs_pkg::ICNT_W'(pcs_pkg::MAX_INTERVALS)
              : pcs_pkg::ICNT_W'(r_icount);
        lk_found = 1'b0;
        lk_idx   = '0;
        for (int i = 0; i < pcs_pkg::MAX_INTERVALS; i++) begin
            if (!lk_found && (pcs_pkg::ICNT_W'(i) < lk_n) && (r_starts[i] > lk_id)) begin
                lk_found = 1'b1;
                lk_idx   = (i == 0) ? '0 : IDX_W'(i - 1);
            end
        end
        if (!lk_found) begin
            lk_idx = (lk_n == '0) ? '0 : IDX_W'(lk_n - pcs_pkg::ICNT_W'(1));
        end
    end

    // Read addresses issued in the accept cycle.
    always_comb begin
        if (w_kind == pcs_pkg::K_READ) begin
            n_pair_addr = {w_row, w_col};
            n_bnd_addr  = w_row;
            n_act_addr  = w_row;
        end else begin
            n_pair_addr = {r_cur, lk_idx};
            n_bnd_addr  = r_cur;
            n_act_addr  = lk_idx;
        end
    end

    // Entries never written since reset read as zero.
    assign pair_cur = r_pair_rd_vld ? r_pair_rd : '0;
    assign bnd_cur  = r_bnd_rd_vld  ? r_bnd_rd  : '0;
    assign act_cur  = r_act_rd_vld  ? r_act_rd  : '0;

    assign e_cross = (r_pair_addr[IDX_W +: IDX_W] != r_pair_addr[IDX_W-1:0]);

    // Write-back decisions and next state for the S_RMW state.
    always_comb begin
        pair_we = 1'b0;
        bnd_we  = 1'b0;
        act_we  = 1'b0;
        rd_done = 1'b0;
        n_state = r_state;
        unique case (r_state)
            pcs_pkg::S_IDLE: begin
                if (s_acc && (w_kind != pcs_pkg::K_LOAD)) begin
                    n_state = pcs_pkg::S_RMW;
                end
            end
            pcs_pkg::S_RMW: begin
                unique case (r_kind)
                    pcs_pkg::K_VERTEX: begin
                        act_we  = r_has;
                        n_state = pcs_pkg::S_IDLE;
                    end
                    pcs_pkg::K_EDGE: begin
                        pair_we = e_cross;
                        bnd_we  = r_last && (r_cross || e_cross);
                        n_state = pcs_pkg::S_IDLE;
                    end
                    pcs_pkg::K_READ: begin
                        if (m_free) begin
                            rd_done = 1'b1;
                            n_state = pcs_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        n_state = pcs_pkg::S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = pcs_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pcs_pkg::S_IDLE;
            r_icount   <= pcs_pkg::CFG_W'(1);
            r_cur      <= '0;
            r_cross    <= 1'b0;
            r_m_valid  <= 1'b0;
            r_pair_vld <= '0;
            r_bnd_vld  <= '0;
            r_act_vld  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_icount <= i_cfg_wdata;
            end
            if (s_acc && (w_kind == pcs_pkg::K_VERTEX)) begin
                r_cur   <= lk_idx;
                r_cross <= 1'b0;
            end
            if ((r_state == pcs_pkg::S_RMW) && (r_kind == pcs_pkg::K_EDGE)) begin
                if (r_last) begin
                    r_cross <= 1'b0;
                end else if (e_cross) begin
                    r_cross <= 1'b1;
                end
            end
            if (rd_done) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (pair_we) begin
                r_pair_vld[r_pair_addr] <= 1'b1;
            end
            if (bnd_we) begin
                r_bnd_vld[r_bnd_addr] <= 1'b1;
            end
            if (act_we) begin
                r_act_vld[r_act_addr] <= 1'b1;
            end
        end
    end

    // Item capture, start table and read ports.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_kind      <= w_kind;
            r_has       <= w_has;
            r_last      <= i_s_tlast;
            r_pair_addr <= n_pair_addr;
            r_bnd_addr  <= n_bnd_addr;
            r_act_addr  <= n_act_addr;
            if (w_kind == pcs_pkg::K_LOAD) begin
                r_starts[w_row] <= w_start;
            end
            r_pair_rd     <= r_pair_mem[n_pair_addr];
            r_bnd_rd      <= r_bnd_mem[n_bnd_addr];
            r_act_rd      <= r_act_mem[n_act_addr];
            r_pair_rd_vld <= r_pair_vld[n_pair_addr];
            r_bnd_rd_vld  <= r_bnd_vld[n_bnd_addr];
            r_act_rd_vld  <= r_act_vld[n_act_addr];
        end
    end

    // Write ports of the counter memories.
    always_ff @(posedge i_clk) begin
        if (pair_we) begin
            r_pair_mem[r_pair_addr] <= sat_inc(pair_cur);
        end
        if (bnd_we) begin
            r_bnd_mem[r_bnd_addr] <= sat_inc(bnd_cur);
        end
        if (act_we) begin
            r_act_mem[r_act_addr] <= sat_inc(act_cur);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (rd_done) begin
            r_m_pair <= pair_cur;
            r_m_bnd  <= bnd_cur;
            r_m_act  <= act_cur;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_act, r_m_bnd, r_m_pair};

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the partition cut statistics unit.
// Depends on pcs_pkg and partition_cut_statistics_unit; it keeps its own copy of the counters and
// checks every read-counters result against it.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_INTERVALS = pcs_pkg::MAX_INTERVALS;
    localparam int IDX_W         = pcs_pkg::IDX_W;
    localparam int ID_BITS       = pcs_pkg::ID_BITS;
    localparam int CNT_W         = pcs_pkg::CNT_W;
    localparam int CFG_W         = pcs_pkg::CFG_W;
    localparam int PART_W        = pcs_pkg::PART_W;
    localparam int KIND_W        = pcs_pkg::KIND_W;
    localparam int IN_DATA_W     = pcs_pkg::IN_DATA_W;
    localparam int OUT_DATA_W    = pcs_pkg::OUT_DATA_W;
    localparam int VID_LSB       = pcs_pkg::VID_LSB;
    localparam int HAS_BIT       = pcs_pkg::HAS_BIT;
    localparam int NID_LSB       = pcs_pkg::NID_LSB;
    localparam int ROW_LSB       = pcs_pkg::ROW_LSB;
    localparam int COL_LSB       = pcs_pkg::COL_LSB;
    localparam int START_LSB     = pcs_pkg::START_LSB;

    typedef struct packed {
        pcs_pkg::t_kind      kind;
        logic [ID_BITS-1:0]  vtx_id;
        logic                has_edges;
        logic [ID_BITS-1:0]  neighbor_id;
        logic                last_edge;
        logic [PART_W-1:0]   part_row;
        logic [PART_W-1:0]   part_col;
        logic [ID_BITS-1:0]  base_id;
    } t_stat_word;

    typedef struct packed {
        logic [CNT_W-1:0] pair_edges;
        logic [CNT_W-1:0] boundary_vertices;
        logic [CNT_W-1:0] active_vertices;
    } t_cut_counts;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata = '0;
    logic [KIND_W-1:0]      i_s_tuser = '0;
    logic                   i_s_tlast = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;

    partition_cut_statistics_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // Local copy of the block state.
    logic [ID_BITS-1:0] start_ids [MAX_INTERVALS];
    logic [CNT_W-1:0]   pair_tally [MAX_INTERVALS][MAX_INTERVALS];
    logic [CNT_W-1:0]   boundary_tally [MAX_INTERVALS];
    logic [CNT_W-1:0]   active_tally [MAX_INTERVALS];
    logic [IDX_W-1:0]   source_interval = '0;
    logic               crossing_pending = 1'b0;
    logic [CFG_W-1:0]   cfg_intervals = 5'd1;

    t_cut_counts pending_counts [$];
    t_cut_counts want_counts;

    int  mismatches = 0;
    int  cycle_count = 0;
    int  words_sent = 0;
    int  rx_hold = 0;
    bit  tx_gaps = 1'b1;
    bit  rx_stalls = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < MAX_INTERVALS; i++) begin
            start_ids[i] = '0;
            boundary_tally[i] = '0;
            active_tally[i] = '0;
            for (int j = 0; j < MAX_INTERVALS; j++) pair_tally[i][j] = '0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    // Interval before the first start that exceeds the id, else the last in use; ids below the first start land in 0.
    function automatic logic [IDX_W-1:0] interval_of(logic [ID_BITS-1:0] id);
        int n;
        n = (cfg_intervals > MAX_INTERVALS) ? MAX_INTERVALS : cfg_intervals;
        for (int i = 0; i < n; i++) begin
            if (start_ids[i] > id) return (i == 0) ? '0 : IDX_W'(i - 1);
        end
        return (n == 0) ? '0 : IDX_W'(n - 1);
    endfunction

    function automatic void update_statistics(t_stat_word w);
        logic [IDX_W-1:0] dst;
        case (w.kind)
            pcs_pkg::K_LOAD: begin
                start_ids[w.part_row] = w.base_id;
            end
            pcs_pkg::K_VERTEX: begin
                source_interval = interval_of(w.vtx_id);
                crossing_pending = 1'b0;
                if (w.has_edges)
                    active_tally[source_interval] = bump(active_tally[source_interval]);
            end
            pcs_pkg::K_EDGE: begin
                dst = interval_of(w.neighbor_id);
                if (dst != source_interval) begin
                    pair_tally[source_interval][dst] = bump(pair_tally[source_interval][dst]);
                    crossing_pending = 1'b1;
                end
                if (w.last_edge) begin
                    if (crossing_pending)
                        boundary_tally[source_interval] = bump(boundary_tally[source_interval]);
                    crossing_pending = 1'b0;
                end
            end
            default: begin
                pending_counts.push_back('{pair_tally[w.part_row][w.part_col],
                                           boundary_tally[w.part_row],
                                           active_tally[w.part_row]});
            end
        endcase
    endfunction

    // Fields a kind does not use are left random so that every field bit moves.
    function automatic t_stat_word noisy_word(pcs_pkg::t_kind k);
        t_stat_word w;
        w.kind        = k;
        w.vtx_id      = $urandom;
        w.has_edges   = 1'($urandom_range(0, 1));
        w.neighbor_id = $urandom;
        w.last_edge   = 1'($urandom_range(0, 1));
        w.part_row    = PART_W'($urandom_range(0, MAX_INTERVALS - 1));
        w.part_col    = PART_W'($urandom_range(0, MAX_INTERVALS - 1));
        w.base_id     = $urandom;
        return w;
    endfunction

    // Ids near the interval starts in use, plus the extremes and plain random ones.
    function automatic logic [ID_BITS-1:0] pick_id();
        int used;
        int k;
        used = (cfg_intervals > MAX_INTERVALS) ? MAX_INTERVALS : cfg_intervals;
        if (used == 0) used = 1;
        k = $urandom_range(0, used - 1);
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return start_ids[k] - 1'b1;
            2: return start_ids[k];
            3: return start_ids[k] + $urandom_range(0, 255);
            default: return $urandom_range(0, 1) ? {ID_BITS{1'b1}} : '0;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
        mismatches++;
        $display("MISMATCH %s: got %08h want %08h at cycle %0d", what, got, want,
                 cycle_count);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_counts.size() == 0) begin
                flag_mismatch("result with nothing pending", o_m_tdata[0 +: CNT_W], '0);
            end else begin
                want_counts = pending_counts.pop_front();
                if (o_m_tdata[0 +: CNT_W] !== want_counts.pair_edges)
                    flag_mismatch("pair_edges", o_m_tdata[0 +: CNT_W], want_counts.pair_edges);
                if (o_m_tdata[CNT_W +: CNT_W] !== want_counts.boundary_vertices)
                    flag_mismatch("boundary_vertices", o_m_tdata[CNT_W +: CNT_W],
                                  want_counts.boundary_vertices);
                if (o_m_tdata[2*CNT_W +: CNT_W] !== want_counts.active_vertices)
                    flag_mismatch("active_vertices", o_m_tdata[2*CNT_W +: CNT_W],
                                  want_counts.active_vertices);
            end
        end
    end

    // Result side ready: random stalls, plus a long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(input t_stat_word w);
        logic [IN_DATA_W-1:0] d;
        int gap;
        d = '0;
        d[VID_LSB +: ID_BITS]   = w.vtx_id;
        d[HAS_BIT]              = w.has_edges;
        d[NID_LSB +: ID_BITS]   = w.neighbor_id;
        d[ROW_LSB +: PART_W]    = w.part_row;
        d[COL_LSB +: PART_W]    = w.part_col;
        d[START_LSB +: ID_BITS] = w.base_id;
        i_s_tdata  <= d;
        i_s_tuser  <= w.kind;
        i_s_tlast  <= w.last_edge;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        update_statistics(w);
        words_sent++;
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            gap = pick_gap();
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_vertex(input logic [ID_BITS-1:0] id, input logic has);
        t_stat_word w;
        w = noisy_word(pcs_pkg::K_VERTEX);
        w.vtx_id = id;
        w.has_edges = has;
        send_word(w);
    endtask

    task automatic send_edge(input logic [ID_BITS-1:0] id, input logic last);
        t_stat_word w;
        w = noisy_word(pcs_pkg::K_EDGE);
        w.neighbor_id = id;
        w.last_edge = last;
        send_word(w);
    endtask

    task automatic send_read(input int row, input int col);
        t_stat_word w;
        w = noisy_word(pcs_pkg::K_READ);
        w.part_row = PART_W'(row);
        w.part_col = PART_W'(col);
        send_word(w);
    endtask

    // Stop offering words, wait for every result, then let the last words settle.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_interval_count(input int value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_intervals = CFG_W'(value);
    endtask

    // Ascending starts; the first one is never zero so that id zero falls below it.
    task automatic load_sorted_table(input int max_step);
        t_stat_word w;
        logic [ID_BITS-1:0] v;
        v = $urandom_range(1, max_step);
        for (int i = 0; i < MAX_INTERVALS; i++) begin
            w = noisy_word(pcs_pkg::K_LOAD);
            w.part_row = PART_W'(i);
            w.base_id = v;
            send_word(w);
            v = v + $urandom_range(1, max_step);
        end
    endtask

    task automatic test_directed_corners();
        set_interval_count(MAX_INTERVALS);
        load_sorted_table(32'h0FFF_FFFF);
        // An edge before any vertex is charged to interval 0.
        send_edge({ID_BITS{1'b1}}, 1'b1);
        send_read(0, MAX_INTERVALS - 1);
        send_vertex('0, 1'b1);
        send_edge(start_ids[0] - 1'b1, 1'b0);
        send_edge({ID_BITS{1'b1}}, 1'b0);
        send_edge(start_ids[0], 1'b1);
        // A second last edge without a new crossing must not count again.
        send_edge('0, 1'b1);
        send_vertex({ID_BITS{1'b1}}, 1'b0);
        send_edge(start_ids[1] - 1'b1, 1'b1);
        send_read(MAX_INTERVALS - 1, 0);
        send_read(0, MAX_INTERVALS - 1);
        send_read(0, 0);
    endtask

    task automatic test_interval_count_extremes();
        set_interval_count(0);
        send_vertex($urandom, 1'b1);
        send_edge({ID_BITS{1'b1}}, 1'b1);
        send_read(0, 0);
        set_interval_count(31);
        send_vertex({ID_BITS{1'b1}}, 1'b1);
        send_edge(start_ids[7] - 1'b1, 1'b1);
        send_read(MAX_INTERVALS - 1, 6);
        set_interval_count(1);
        send_vertex($urandom, 1'b1);
        send_edge($urandom, 1'b1);
        send_read(0, 0);
    endtask

    task automatic test_random_streams();
        int counts [7];
        int phase_end;
        int n_edges;
        t_stat_word w;
        counts = '{16, 1, 0, 31, 0, 0, 16};
        counts[4] = $urandom_range(2, 15);
        counts[5] = $urandom_range(17, 30);
        for (int p = 0; p < 7; p++) begin
            tx_gaps   = (p % 3 != 1);
            rx_stalls = (p % 3 != 2);
            set_interval_count(counts[p]);
            load_sorted_table((p % 2 == 0) ? 32'h0FFF_FFFF : 64);
            phase_end = words_sent + 154;
            while (words_sent < phase_end) begin
                case ($urandom_range(0, 19))
                    0, 1: begin
                        send_read($urandom_range(0, MAX_INTERVALS - 1),
                                  $urandom_range(0, MAX_INTERVALS - 1));
                    end
                    2, 3, 4: begin
                        // Broken sequences: stray edges, stray vertices, table overwrites.
                        case ($urandom_range(0, 4))
                            0: begin
                                w = noisy_word(pcs_pkg::K_LOAD);
                                if ($urandom_range(0, 1)) w.base_id = pick_id();
                                send_word(w);
                            end
                            1, 2: begin
                                w = noisy_word(pcs_pkg::K_EDGE);
                                w.neighbor_id = pick_id();
                                send_word(w);
                            end
                            default: send_word(noisy_word(pcs_pkg::K_VERTEX));
                        endcase
                    end
                    default: begin
                        send_vertex(pick_id(), 1'($urandom_range(0, 9) != 0));
                        n_edges = $urandom_range(0, 5);
                        for (int e = 0; e < n_edges; e++)
                            send_edge(pick_id(), 1'(e == n_edges - 1));
                        if ($urandom_range(0, 2) == 0)
                            send_read(source_interval, $urandom_range(0, MAX_INTERVALS - 1));
                    end
                endcase
            end
        end
    endtask

    task automatic test_result_backpressure();
        wait_idle();
        tx_gaps = 1'b0;
        rx_stalls = 1'b1;
        rx_hold = 300;
        // The held result blocks the second read, so the input must stall.
        repeat (12) begin
            send_vertex(pick_id(), 1'b1);
            send_edge(pick_id(), 1'b1);
            send_read($urandom_range(0, MAX_INTERVALS - 1), $urandom_range(0, MAX_INTERVALS - 1));
        end
        wait_idle();
        tx_gaps = 1'b1;
        repeat (6) begin
            send_read($urandom_range(0, MAX_INTERVALS - 1), $urandom_range(0, MAX_INTERVALS - 1));
            send_edge(pick_id(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_interval_count_extremes();
        test_random_streams();
        test_result_backpressure();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/pcs_pkg.sv
design/partition_cut_statistics_unit.sv
dv/testbench.sv
